### design/fsfm_pkg.sv
package fsfm_pkg;

   // Request payload widths
   localparam int RAW_SPEED_W = 8;
   localparam int FAN_STATE_W = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 1;

   // Response payload widths
   localparam int SPEED_RPM_W = 14;
   localparam int RSP_DATA_W  = 24;

   // Configuration widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SPEED_W     = 16;
   localparam int RETRIES_W   = 8;
   localparam int COUNT_W     = 9;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ALERTS_BYPASS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WARNING_SPEED    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CRITICAL_SPEED   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WARNING_RETRIES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CRITICAL_RETRIES = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SUPPRESS_WARNING = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAIN_FAN_MASK    = 3'd6;

   // Operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Reset values
   localparam logic [RETRIES_W-1:0] RETRIES_RESET   = 8'd3;
   localparam logic [SPEED_W-1:0]   FAN_MASK_RESET  = 16'd1;

   typedef struct packed {
      logic                   error_status;
      logic                   warning_alarm;
      logic                   critical_alarm;
      logic                   fan_on;
      logic [SPEED_RPM_W-1:0] speed_rpm;
   } rsp_fields_type;

   // 60 * raw = 64 * raw - 4 * raw; max 15300 fits in 14 bits
   function automatic logic [SPEED_RPM_W-1:0] to_rpm(input logic [RAW_SPEED_W-1:0] raw);
      logic [SPEED_RPM_W-1:0] raw_ext;
      raw_ext = {{(SPEED_RPM_W-RAW_SPEED_W){1'b0}}, raw};
      return (raw_ext << 6) - (raw_ext << 2);
   endfunction

endpackage

### design/fan_speed_fault_monitor_unit.sv
// Channel  | Ports                         | Payload (low bit up)
// ---------+-------------------------------+-----------------------------------------------
// request  | req_tvalid/tready/tdata/tuser | tdata: raw_speed[7:0], fan_state[23:8]
//          |                               | tuser: operation[0] (0 sample, 1 clear)
// response | rsp_tvalid/tready/tdata       | tdata: speed_rpm[13:0], fan_on[14],
//          |                               | critical_alarm[15], warning_alarm[16],
//          |                               | error_status[17], zero[23:18]
// config   | csr_valid/ready/index/data    | index 0..6, data low bits hold the register
//
// One request per cycle sustained while the response is taken. A request lands in the
// input register; the counter update and alarm logic run combinationally between it
// and the response register.
// Reset is synchronous, active high: resets valid bits, counters and config registers.
// A stalled response holds; the input register takes one more request, then holds input.
module fan_speed_fault_monitor_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [fsfm_pkg::REQ_DATA_W-1:0]       req_tdata,  // raw_speed, fan_state
   input  logic [fsfm_pkg::REQ_USER_W-1:0]       req_tuser,  // operation
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fsfm_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // speed_rpm, fan_on,
                                                             // critical_alarm,
                                                             // warning_alarm, error_status
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fsfm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fsfm_pkg::CSR_DATA_W-1:0]       csr_data
);

   // ---------------- configuration registers ----------------
   logic                                alerts_bypass_ff;
   logic [fsfm_pkg::SPEED_W-1:0]        warning_speed_ff;
   logic [fsfm_pkg::SPEED_W-1:0]        critical_speed_ff;
   logic [fsfm_pkg::RETRIES_W-1:0]      warning_retries_ff;
   logic [fsfm_pkg::RETRIES_W-1:0]      critical_retries_ff;
   logic                                suppress_warning_ff;
   logic [fsfm_pkg::SPEED_W-1:0]        main_fan_mask_ff;

   // Always take config writes; the user must send them only while idle, unchecked.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alerts_bypass_ff    <= 1'b0;
         warning_speed_ff    <= '0;
         critical_speed_ff   <= '0;
         warning_retries_ff  <= fsfm_pkg::RETRIES_RESET;
         critical_retries_ff <= fsfm_pkg::RETRIES_RESET;
         suppress_warning_ff <= 1'b0;
         main_fan_mask_ff    <= fsfm_pkg::FAN_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fsfm_pkg::REG_ALERTS_BYPASS:    alerts_bypass_ff    <= csr_data[0];
            fsfm_pkg::REG_WARNING_SPEED:    warning_speed_ff    <= csr_data;
            fsfm_pkg::REG_CRITICAL_SPEED:   critical_speed_ff   <= csr_data;
            fsfm_pkg::REG_WARNING_RETRIES:
               warning_retries_ff  <= csr_data[fsfm_pkg::RETRIES_W-1:0];
            fsfm_pkg::REG_CRITICAL_RETRIES:
               critical_retries_ff <= csr_data[fsfm_pkg::RETRIES_W-1:0];
            fsfm_pkg::REG_SUPPRESS_WARNING: suppress_warning_ff <= csr_data[0];
            fsfm_pkg::REG_MAIN_FAN_MASK:    main_fan_mask_ff    <= csr_data;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic in_valid_ff;
   logic rsp_valid_ff;
   logic advance;

   // Move the input register forward whenever the response slot is free or draining.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (advance)
            rsp_valid_ff <= in_valid_ff;
      end
   end

   // ---------------- input register ----------------
   logic                                   op_ff;
   logic [fsfm_pkg::RAW_SPEED_W-1:0]       raw_speed_ff;
   logic [fsfm_pkg::FAN_STATE_W-1:0]       fan_state_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff        <= req_tuser[0];
         raw_speed_ff <= req_tdata[fsfm_pkg::RAW_SPEED_W-1:0];
         fan_state_ff <= req_tdata[fsfm_pkg::RAW_SPEED_W +: fsfm_pkg::FAN_STATE_W];
      end
   end

   // ---------------- monitor logic ----------------
   logic [fsfm_pkg::COUNT_W-1:0]     warning_count_ff;
   logic [fsfm_pkg::COUNT_W-1:0]     critical_count_ff;
   logic [fsfm_pkg::COUNT_W-1:0]     warning_count_in;
   logic [fsfm_pkg::COUNT_W-1:0]     critical_count_in;
   logic [fsfm_pkg::COUNT_W-1:0]     warn_retries_ext;
   logic [fsfm_pkg::COUNT_W-1:0]     crit_retries_ext;
   logic [fsfm_pkg::COUNT_W-1:0]     count_step;
   logic [fsfm_pkg::SPEED_RPM_W-1:0] speed;
   logic [fsfm_pkg::SPEED_W-1:0]     speed_ext;
   logic                             fan_on;
   logic                             crit_pulse;
   logic                             warn_pulse;
   fsfm_pkg::rsp_fields_type         result;

   assign speed            = fsfm_pkg::to_rpm(raw_speed_ff);
   assign speed_ext        = {{(fsfm_pkg::SPEED_W-fsfm_pkg::SPEED_RPM_W){1'b0}}, speed};
   assign fan_on           = |(fan_state_ff & main_fan_mask_ff);
   assign warn_retries_ext = {1'b0, warning_retries_ff};
   assign crit_retries_ext = {1'b0, critical_retries_ff};
   assign count_step       = {{(fsfm_pkg::COUNT_W-1){1'b0}}, 1'b1};

   always_comb begin
      warning_count_in  = warning_count_ff;
      critical_count_in = critical_count_ff;
      crit_pulse        = 1'b0;
      warn_pulse        = 1'b0;
      if (op_ff == fsfm_pkg::OP_CLEAR) begin
         warning_count_in  = '0;
         critical_count_in = '0;
      end else begin
         if (!fan_on) begin
            warning_count_in  = '0;
            critical_count_in = '0;
         end else if (!alerts_bypass_ff) begin
            // Count slow samples, saturating at the retry count; a good sample clears.
            if (warning_speed_ff > speed_ext) begin
               if (warn_retries_ext > warning_count_ff)
                  warning_count_in = warning_count_ff + count_step;
               if (critical_speed_ff > speed_ext && crit_retries_ext > critical_count_ff)
                  critical_count_in = critical_count_ff + count_step;
            end else begin
               warning_count_in  = '0;
               critical_count_in = '0;
            end
            // Fire once: step past the retry count so the alarm does not repeat.
            priority if (critical_count_in == crit_retries_ext) begin
               critical_count_in = critical_count_in + count_step;
               warning_count_in  = warn_retries_ext + count_step;
               crit_pulse        = 1'b1;
            end else if (warning_count_in == warn_retries_ext && !suppress_warning_ff) begin
               warning_count_in = warning_count_in + count_step;
               warn_pulse       = 1'b1;
            end else begin
               // no alarm: keep the counts
            end
         end
      end

      result.speed_rpm      = speed;
      result.fan_on         = fan_on;
      result.critical_alarm = crit_pulse;
      result.warning_alarm  = warn_pulse;
      result.error_status   = (warn_retries_ext <= warning_count_in);
   end

   // Counters advance only when the request leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         warning_count_ff  <= '0;
         critical_count_ff <= '0;
      end else if (in_valid_ff && advance) begin
         warning_count_ff  <= warning_count_in;
         critical_count_ff <= critical_count_in;
      end
   end

   // ---------------- response register ----------------
   fsfm_pkg::rsp_fields_type rsp_fields_ff;

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance)
         rsp_fields_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(fsfm_pkg::RSP_DATA_W-$bits(fsfm_pkg::rsp_fields_type)){1'b0}},
                        rsp_fields_ff};

endmodule

### tb/tb_fan_speed_fault_monitor_unit.sv
`timescale 1ns / 1ps

module tb_fan_speed_fault_monitor_unit;

   // Hard stop for the whole run
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                             op;
      logic [fsfm_pkg::RAW_SPEED_W-1:0] raw;
      logic [fsfm_pkg::FAN_STATE_W-1:0] state;
   } fan_request_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [fsfm_pkg::REQ_DATA_W-1:0]  req_tdata = '0;   // raw_speed[7:0], fan_state[23:8]
   logic [fsfm_pkg::REQ_USER_W-1:0]  req_tuser = '0;   // operation[0]
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [fsfm_pkg::RSP_DATA_W-1:0]  rsp_tdata;        // speed_rpm[13:0], fan_on[14],
                                                       // critical_alarm[15],
                                                       // warning_alarm[16],
                                                       // error_status[17], zero[23:18]
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [fsfm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [fsfm_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // Pending requests, the request on the bus and the expected responses
   fan_request_type          pending_q[$];
   fan_request_type          bus_req = '0;
   fsfm_pkg::rsp_fields_type fan_status_q[$];
   bit                       req_busy = 1'b0;
   bit                       req_taken = 1'b0;
   bit                       steady = 1'b0;

   // Shadow copy of the register file and of the retry counters
   logic                           cfg_bypass = 1'b0;
   logic [fsfm_pkg::SPEED_W-1:0]   cfg_warn_speed = '0;
   logic [fsfm_pkg::SPEED_W-1:0]   cfg_crit_speed = '0;
   logic [fsfm_pkg::RETRIES_W-1:0] cfg_warn_retries = fsfm_pkg::RETRIES_RESET;
   logic [fsfm_pkg::RETRIES_W-1:0] cfg_crit_retries = fsfm_pkg::RETRIES_RESET;
   logic                           cfg_suppress = 1'b0;
   logic [fsfm_pkg::SPEED_W-1:0]   cfg_fan_mask = fsfm_pkg::FAN_MASK_RESET;
   logic [fsfm_pkg::COUNT_W-1:0]   warn_count = '0;
   logic [fsfm_pkg::COUNT_W-1:0]   crit_count = '0;

   int error_count = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int config_count = 0;
   int crit_alarms = 0;
   int warn_alarms = 0;
   int cycle_count = 0;

   fan_speed_fault_monitor_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the shadow counters by one request and return the status it yields
   function automatic fsfm_pkg::rsp_fields_type predict_fan_status(
         input fan_request_type item);
      fsfm_pkg::rsp_fields_type     res;
      logic [fsfm_pkg::SPEED_W-1:0] rpm;
      logic                         on;
      logic [fsfm_pkg::COUNT_W-1:0] warn_lim;
      logic [fsfm_pkg::COUNT_W-1:0] crit_lim;
      res = '0;
      rpm = item.raw * 16'd60;
      on = |(item.state & cfg_fan_mask);
      warn_lim = {1'b0, cfg_warn_retries};
      crit_lim = {1'b0, cfg_crit_retries};
      if (item.op == fsfm_pkg::OP_CLEAR) begin
         warn_count = '0;
         crit_count = '0;
      end else begin
         if (!on) begin
            warn_count = '0;
            crit_count = '0;
         end
         if (on && !cfg_bypass) begin
            if (cfg_warn_speed > rpm) begin
               if (warn_lim > warn_count) warn_count = warn_count + 9'd1;
               if (cfg_crit_speed > rpm && crit_lim > crit_count) begin
                  crit_count = crit_count + 9'd1;
               end
            end else begin
               // good speed drops both counters
               warn_count = '0;
               crit_count = '0;
            end
            // critical wins over warning; both push their counter past the limit, a suppressed warning not
            if (crit_count == crit_lim) begin
               crit_count = crit_count + 9'd1;
               warn_count = warn_lim + 9'd1;
               res.critical_alarm = 1'b1;
            end else if (warn_count == warn_lim) begin
               if (!cfg_suppress) begin
                  warn_count = warn_count + 9'd1;
                  res.warning_alarm = 1'b1;
               end
            end
         end
      end
      res.speed_rpm = rpm[fsfm_pkg::SPEED_RPM_W-1:0];
      res.fan_on = on;
      res.error_status = (warn_lim <= warn_count);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("MISMATCH response %0d %s: got %0d, want %0d", results_checked, field,
               got, want);
      error_count++;
   endtask

   // Sample both handshakes at the rising edge
   always @(posedge clock) begin : monitor
      fsfm_pkg::rsp_fields_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, fan_status_q.size());
         $display("Regression FAIL");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (fan_status_q.size() == 0) begin
               report_mismatch("unexpected response tdata", int'(rsp_tdata), 0);
            end else begin
               want = fan_status_q.pop_front();
               if (rsp_tdata[13:0] !== want.speed_rpm)
                  report_mismatch("speed_rpm", int'(rsp_tdata[13:0]),
                                  int'(want.speed_rpm));
               if (rsp_tdata[14] !== want.fan_on)
                  report_mismatch("fan_on", int'(rsp_tdata[14]), int'(want.fan_on));
               if (rsp_tdata[15] !== want.critical_alarm)
                  report_mismatch("critical_alarm", int'(rsp_tdata[15]),
                                  int'(want.critical_alarm));
               if (rsp_tdata[16] !== want.warning_alarm)
                  report_mismatch("warning_alarm", int'(rsp_tdata[16]),
                                  int'(want.warning_alarm));
               if (rsp_tdata[17] !== want.error_status)
                  report_mismatch("error_status", int'(rsp_tdata[17]),
                                  int'(want.error_status));
               if (rsp_tdata[23:18] !== '0)
                  report_mismatch("pad bits", int'(rsp_tdata[23:18]), 0);
               if (want.critical_alarm) crit_alarms++;
               if (want.warning_alarm) warn_alarms++;
            end
            results_checked++;
         end
         // predict after the check: a request never answers in its own cycle
         if (req_tvalid && req_tready) begin
            fan_status_q.push_back(predict_fan_status(bus_req));
            requests_sent++;
            req_taken = 1'b1;
         end
      end
   end

   // Drive requests and response backpressure at the falling edge
   always @(negedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_taken) req_busy = 1'b0;
         req_taken = 1'b0;
         // hold a presented request until it is taken; idle only between requests
         if (!req_busy && pending_q.size() > 0 && (steady || $urandom_range(0, 99) >= 10))
         begin
            bus_req = pending_q.pop_front();
            req_busy = 1'b1;
         end
         req_tvalid <= req_busy;
         req_tdata  <= {bus_req.state, bus_req.raw};
         req_tuser  <= bus_req.op;
         rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   task automatic write_csr(input logic [fsfm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         fsfm_pkg::REG_ALERTS_BYPASS:    cfg_bypass       = value[0];
         fsfm_pkg::REG_WARNING_SPEED:    cfg_warn_speed   = value;
         fsfm_pkg::REG_CRITICAL_SPEED:   cfg_crit_speed   = value;
         fsfm_pkg::REG_WARNING_RETRIES:  cfg_warn_retries = value[fsfm_pkg::RETRIES_W-1:0];
         fsfm_pkg::REG_CRITICAL_RETRIES: cfg_crit_retries = value[fsfm_pkg::RETRIES_W-1:0];
         fsfm_pkg::REG_SUPPRESS_WARNING: cfg_suppress     = value[0];
         fsfm_pkg::REG_MAIN_FAN_MASK:    cfg_fan_mask     = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic bypass, input logic [15:0] warn_speed,
                             input logic [15:0] crit_speed, input logic [7:0] warn_retries,
                             input logic [7:0] crit_retries, input logic suppress,
                             input logic [15:0] fan_mask);
      write_csr(fsfm_pkg::REG_ALERTS_BYPASS, {15'd0, bypass});
      write_csr(fsfm_pkg::REG_WARNING_SPEED, warn_speed);
      write_csr(fsfm_pkg::REG_CRITICAL_SPEED, crit_speed);
      write_csr(fsfm_pkg::REG_WARNING_RETRIES, {8'd0, warn_retries});
      write_csr(fsfm_pkg::REG_CRITICAL_RETRIES, {8'd0, crit_retries});
      write_csr(fsfm_pkg::REG_SUPPRESS_WARNING, {15'd0, suppress});
      write_csr(fsfm_pkg::REG_MAIN_FAN_MASK, fan_mask);
      config_count++;
   endtask

   // Hold until every queued request is answered; registers change only then
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_busy || fan_status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_request(input logic op, input logic [7:0] raw,
                                input logic [15:0] state);
      fan_request_type item;
      item.op = op;
      item.raw = raw;
      item.state = state;
      pending_q.push_back(item);
   endtask

   function automatic logic [7:0] raw_below(input int limit);
      int top;
      if (limit <= 0) return 8'($urandom_range(0, 255));
      top = (limit - 1) / 60;
      if (top > 255) top = 255;
      return 8'($urandom_range(0, top));
   endfunction

   function automatic logic [7:0] raw_between(input int lo_rpm, input int hi_rpm);
      int low;
      int top;
      low = (lo_rpm + 59) / 60;
      top = (hi_rpm - 1) / 60;
      if (top > 255) top = 255;
      if (hi_rpm <= 0 || low > top) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(low, top));
   endfunction

   // State word with at least one mask bit set if any exist, none when the fan reads off
   function automatic logic [15:0] fan_word(input bit on);
      logic [15:0] word;
      int          b;
      word = 16'($urandom);
      if (!on) return word & ~cfg_fan_mask;
      if (cfg_fan_mask == '0) return word;
      do b = int'($urandom_range(0, 15)); while (!cfg_fan_mask[b]);
      word[b] = 1'b1;
      return word;
   endfunction

   task automatic queue_random_requests(input int count);
      int          pick;
      logic        op;
      logic [7:0]  raw;
      logic [15:0] state;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         op = ($urandom_range(0, 99) < 5) ? fsfm_pkg::OP_CLEAR : fsfm_pkg::OP_SAMPLE;
         if (pick < 10) begin
            // noise
            raw = 8'($urandom_range(0, 255));
            state = 16'($urandom);
         end else begin
            state = fan_word($urandom_range(0, 99) >= 6);
            if (pick < 55) raw = raw_below(cfg_crit_speed);
            else if (pick < 85) raw = raw_between(cfg_crit_speed, cfg_warn_speed);
            else raw = raw_between(cfg_warn_speed, 15360);
         end
         queue_request(op, raw, state);
      end
   endtask

   task automatic apply_random_config();
      logic        bypass;
      logic        suppress;
      logic [15:0] ws;
      logic [15:0] cs;
      logic [7:0]  wr;
      logic [7:0]  cr;
      logic [15:0] mask;
      int          pick;
      bypass = ($urandom_range(0, 9) == 0);
      suppress = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      ws = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(60, 15360));
      pick = $urandom_range(0, 19);
      cs = (pick < 2) ? 16'd0 : (pick == 2) ? 16'hFFFF : 16'($urandom_range(0, ws));
      pick = $urandom_range(0, 19);
      wr = (pick < 3) ? 8'd0 : (pick == 3) ? 8'd255 : 8'($urandom_range(1, 6));
      pick = $urandom_range(0, 19);
      cr = (pick < 3) ? 8'd0 : (pick == 3) ? 8'd255 : 8'($urandom_range(wr, wr + 4));
      pick = $urandom_range(0, 9);
      mask = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
             (pick < 6) ? 16'(1 << $urandom_range(0, 15)) : 16'($urandom);
      set_config(bypass, ws, cs, wr, cr, suppress, mask);
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: warning level zero, nothing counts
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h0001);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd255, 16'hFFFF);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd7, 16'h0000);
      wait_drained();

      // Warning below 600 rpm, critical below 300 rpm
      set_config(1'b0, 16'd600, 16'd300, 8'd2, 8'd4, 1'b0, 16'h0001);
      repeat (3) queue_request(fsfm_pkg::OP_SAMPLE, 8'd8, 16'h0001);  // warning fires once
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'hFFFF);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd4, 16'h0001);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd1, 16'h0001);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h0001);         // critical fires
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h0001);         // no repeat
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd10, 16'h0001);        // exactly at warning level
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd9, 16'h0001);
      queue_request(fsfm_pkg::OP_CLEAR, 8'd255, 16'hFFFF);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd9, 16'h0001);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd9, 16'hFFFE);         // fan off
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd255, 16'hFFFF);
      wait_drained();

      // Zero retries: alarm on the first active sample, even a good one
      set_config(1'b0, 16'd600, 16'd300, 8'd0, 8'd0, 1'b0, 16'h8000);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd200, 16'h8000);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h8000);
      queue_request(fsfm_pkg::OP_CLEAR, 8'd0, 16'h0000);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'hFFFF);
      wait_drained();

      // Suppressed warning, then bypass
      set_config(1'b0, 16'hFFFF, 16'hFFFF, 8'd3, 8'd5, 1'b1, 16'hFFFF);
      repeat (5) queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h0100);
      wait_drained();
      write_csr(fsfm_pkg::REG_ALERTS_BYPASS, 16'd1);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h0100);
      queue_request(fsfm_pkg::OP_SAMPLE, 8'd0, 16'h0000);
      wait_drained();

      // Random settings; counters carry across retry changes since nothing clears them
      for (int phase = 0; phase < 8; phase++) begin
         apply_random_config();
         queue_random_requests(40);
         wait_drained();
      end

      // Largest retry counts: long run of slow samples with no idling
      set_config(1'b0, 16'hFFFF, 16'hFFFF, 8'd254, 8'd255, 1'b0, 16'hFFFF);
      steady = 1'b1;
      repeat (262) queue_request(fsfm_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)),
                                 16'($urandom | 1));
      wait_drained();
      steady = 1'b0;

      apply_random_config();
      queue_random_requests(40);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d responses to %0d requests over %0d register settings",
               results_checked, requests_sent, config_count);
      $display("Alarms seen: %0d critical, %0d warning; %0d mismatches",
               crit_alarms, warn_alarms, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
